@@ hw/rtl/siq_pkg.sv @@
// Shared types and constants for the sorted-insert priority queue.
// No dependencies; imported by every module of the block.
package siq_pkg;

    // Store geometry
    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Operation codes
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Request payload
    typedef struct packed {
        logic               cmd;
        logic signed [31:0] value;
    } siq_req_t;

    // Response payload
    typedef struct packed {
        logic signed [31:0] popped_value;
        logic [1:0]         status;
        logic [4:0]         count;
    } siq_rsp_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       load;
        logic       exec;
        logic       do_push;
        logic       do_pop;
        logic [1:0] status;
    } siq_ctrl_t;

    // Datapath to controller status
    typedef struct packed {
        logic pend_cmd;
        logic full;
        logic empty;
    } siq_stat_t;

endpackage

@@ hw/rtl/siq_datapath.sv @@
// Datapath: request holding register, sorted entry store, entry count and
// response register. Depends on siq_pkg.
module siq_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  siq_pkg::siq_req_t  req,
    input  siq_pkg::siq_ctrl_t ctrl,
    output siq_pkg::siq_stat_t stat,
    output siq_pkg::siq_rsp_t  rsp
);
    import siq_pkg::*;

    siq_req_t               req_reg;
    siq_rsp_t               rsp_reg;
    siq_rsp_t               rsp_next;
    logic signed [31:0]     entries_reg [DEPTH];
    logic signed [31:0]     entries_next [DEPTH];
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [DEPTH-1:0]       lt;
    logic [DEPTH-1:0]       prev_lt;
    logic [IDX_W-1:0]       tail_idx;
    logic signed [31:0]     tail_value;
    logic [31:0]            count_ext;

    // Status towards the controller
    assign stat.pend_cmd = req_reg.cmd;
    assign stat.full     = (count_reg == CNT_W'(DEPTH));
    assign stat.empty    = (count_reg == '0);

    // Tail entry, the largest stored value
    assign tail_idx   = IDX_W'(count_reg - 1'b1);
    assign tail_value = entries_reg[tail_idx];

    // Per-entry compare: stored and smaller than the new value
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            lt[i] = (CNT_W'(i) < count_reg) && (entries_reg[i] < req_reg.value);
        end
        prev_lt[0] = 1'b1;
        for (int i = 1; i < DEPTH; i++)
        begin
            prev_lt[i] = lt[i-1];
        end
    end

    // Insert: keep smaller entries, place value at the boundary, shift the rest up
    always_comb
    begin
        entries_next[0] = lt[0] ? entries_reg[0] : req_reg.value;
        for (int i = 1; i < DEPTH; i++)
        begin
            if (lt[i])
                entries_next[i] = entries_reg[i];
            else if (prev_lt[i])
                entries_next[i] = req_reg.value;
            else
                entries_next[i] = entries_reg[i-1];
        end
    end

    // Next count and response
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.do_push)
            count_next = count_reg + 1'b1;
        else if (ctrl.do_pop)
            count_next = count_reg - 1'b1;
        count_ext             = 32'(count_next);
        rsp_next.popped_value = ctrl.do_pop ? tail_value : 32'sd0;
        rsp_next.status       = ctrl.status;
        rsp_next.count        = count_ext[4:0];
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
            req_reg <= req;
        if (ctrl.exec)
            rsp_reg <= rsp_next;
        if (ctrl.do_push)
            entries_reg <= entries_next;
    end

    // Entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    assign rsp = rsp_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.do_push |=> count_reg == $past(count_reg) + 1'b1)
        else $error("push did not grow the store");

    a_pop_tail: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.do_pop |=> rsp_reg.popped_value == $past(tail_value))
        else $error("pop did not return the tail");

    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= CNT_W'(2) |-> entries_reg[0] <= entries_reg[1])
        else $error("head entries out of order");
`endif

endmodule

@@ hw/rtl/siq_controller.sv @@
// Controller: request handshake, execute sequencing and response valid.
// Depends on siq_pkg.
module siq_controller (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    input  siq_pkg::siq_stat_t stat,
    output siq_pkg::siq_ctrl_t ctrl
);
    import siq_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   rsp_free;

    // Response register can take a new result this cycle
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    // Commands and next state
    always_comb
    begin
        ctrl           = '0;
        ctrl.status    = ST_OK;
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                ctrl.load = req_valid;
                if (req_valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (rsp_free)
                begin
                    ctrl.exec      = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (stat.pend_cmd == CMD_PUSH)
                    begin
                        if (stat.full)
                            ctrl.status = ST_FULL;
                        else
                            ctrl.do_push = 1'b1;
                    end
                    else
                    begin
                        if (stat.empty)
                            ctrl.status = ST_EMPTY;
                        else
                            ctrl.do_pop = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.exec |-> !(rsp_valid_reg && rsp_stall))
        else $error("stalled response overwritten");

    a_exec_follows_load: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load |=> state_reg == S_EXEC)
        else $error("loaded request not executed");

    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctrl.do_push, ctrl.do_pop})
        && (!(ctrl.do_push || ctrl.do_pop) || ctrl.exec))
        else $error("bad datapath action");
`endif

endmodule

@@ hw/rtl/sorted_insert_priority_queue_unit.sv @@
// Sorted-insert priority queue, top level: controller plus datapath.
// Depends on siq_pkg, siq_controller and siq_datapath.
//
// Usage:
//   Request channel req/req_valid/req_stall carries cmd (push or pop) and a
//   signed 32-bit value. Response channel rsp/rsp_valid/rsp_stall returns one
//   result per request: popped value (zero unless a pop succeeded), status
//   (ok, pop on empty, push on full) and the entry count after the request.
//   A transfer happens on a rising edge with valid high and stall low.
//   The request is captured in the request register; in the execute state
//   the result goes to the response register and response valid is set,
//   provided the response register is free. A new request is refused until
//   the last one has executed; the whole store updates at once, all entries
//   compared against the new value and shifted up past the insertion point.
//   A push into a full store is dropped; a pop of an empty store changes
//   nothing. Entries are kept smallest first; pop takes the largest.
//   Reset empties the store (count zero) and clears the response valid flag.
//   While the receiver stalls, the response register holds its result; one
//   further request is still taken and waits until the register frees up.
module sorted_insert_priority_queue_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  siq_pkg::siq_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output siq_pkg::siq_rsp_t rsp
);
    import siq_pkg::*;

    siq_ctrl_t ctrl;
    siq_stat_t stat;

    // Sequencing
    siq_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    // Store and result
    siq_datapath u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .ctrl  (ctrl),
        .stat  (stat),
        .rsp   (rsp)
    );

endmodule

@@ dv/tb_sorted_insert_priority_queue_unit.sv @@
// Self-checking testbench for the sorted-insert priority queue unit.
// Depends on siq_pkg and sorted_insert_priority_queue_unit; runs a directed
// table, then random fill/drain/mixed phases, checked by a software store.
`timescale 1ns / 100ps

module tb_sorted_insert_priority_queue_unit;
    import siq_pkg::*;

    localparam int LIMIT_CYCLES = 200_000;
    localparam int RANDOM_ITEMS = 750;
    localparam int CALM_TAIL    = 100;
    localparam int HOLD_AT      = 200;
    localparam int HOLD_CYCLES  = 64;
    localparam int MAX_PRINTS   = 40;
    localparam int N_ROWS       = 20;

    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} phase_mode_t;

    // One row of the directed table; want_* used only when typed is set
    typedef struct {
        logic               cmd;
        logic signed [31:0] value;
        bit                 typed;
        logic signed [31:0] want_value;
        logic [1:0]         want_status;
        logic [4:0]         want_count;
    } stim_row_t;

    stim_row_t stim_rows [N_ROWS] = '{
        '{CMD_POP,  32'sd0,            1'b1, 32'sd0,            ST_EMPTY, 5'd0},
        '{CMD_PUSH, 32'sh7FFF_FFFF,    1'b1, 32'sd0,            ST_OK,    5'd1},
        '{CMD_PUSH, 32'sh8000_0000,    1'b1, 32'sd0,            ST_OK,    5'd2},
        '{CMD_PUSH, 32'sd0,            1'b0, 32'sd0,            ST_OK,    5'd0},
        '{CMD_PUSH, 32'sd0,            1'b0, 32'sd0,            ST_OK,    5'd0},
        '{CMD_PUSH, -32'sd1,           1'b0, 32'sd0,            ST_OK,    5'd0},
        '{CMD_PUSH, 32'sd1,            1'b0, 32'sd0,            ST_OK,    5'd0},
        '{CMD_PUSH, 32'sh7FFF_FFFF,    1'b0, 32'sd0,            ST_OK,    5'd0},
        '{CMD_POP,  32'sh1234_5678,    1'b1, 32'sh7FFF_FFFF,    ST_OK,    5'd6},
        '{CMD_POP,  32'sd0,            1'b1, 32'sh7FFF_FFFF,    ST_OK,    5'd5},
        '{CMD_POP,  32'sd0,            1'b0, 32'sd0,            ST_OK,    5'd0},
        '{CMD_POP,  32'sd0,            1'b0, 32'sd0,            ST_OK,    5'd0},
        '{CMD_POP,  32'sd0,            1'b0, 32'sd0,            ST_OK,    5'd0},
        '{CMD_POP,  32'sd0,            1'b0, 32'sd0,            ST_OK,    5'd0},
        '{CMD_POP,  -32'sd1,           1'b1, 32'sh8000_0000,    ST_OK,    5'd0},
        '{CMD_POP,  32'sd0,            1'b1, 32'sd0,            ST_EMPTY, 5'd0},
        '{CMD_PUSH, 32'sh5555_5555,    1'b0, 32'sd0,            ST_OK,    5'd0},
        '{CMD_PUSH, 32'shAAAA_AAAA,    1'b0, 32'sd0,            ST_OK,    5'd0},
        '{CMD_POP,  32'sd0,            1'b1, 32'sh5555_5555,    ST_OK,    5'd1},
        '{CMD_POP,  32'sd0,            1'b1, 32'shAAAA_AAAA,    ST_OK,    5'd0}
    };

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    siq_req_t  req;
    logic      rsp_valid;
    logic      rsp_stall;
    siq_rsp_t  rsp;

    // Software copy of the store, smallest first
    logic signed [31:0] sorted_entries [$];
    siq_rsp_t           awaited_results [$];

    int  fault_count = 0;
    int  sent_count;
    int  checked_count = 0;
    int  full_refusals;
    int  empty_pops;
    int  cycle_count;
    logic calm;
    logic long_hold;

    sorted_insert_priority_queue_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Update the software store for one request and return its result
    function automatic siq_rsp_t apply_to_store(input siq_req_t item);
        siq_rsp_t           outcome;
        logic signed [31:0] v;
        int                 pos;
        outcome        = '0;
        outcome.status = ST_OK;
        v              = item.value;
        if (item.cmd == CMD_PUSH)
        begin
            if (sorted_entries.size() >= DEPTH)
            begin
                outcome.status = ST_FULL;
            end
            else
            begin
                // new value goes ahead of the first entry not smaller than it
                pos = 0;
                while (pos < sorted_entries.size() && sorted_entries[pos] < v)
                    pos++;
                sorted_entries.insert(pos, v);
            end
        end
        else if (sorted_entries.size() == 0)
        begin
            outcome.status = ST_EMPTY;
        end
        else
        begin
            outcome.popped_value = sorted_entries.pop_back();
        end
        outcome.count = 5'(sorted_entries.size());
        return outcome;
    endfunction

    task automatic report_fault(input string msg);
        if (fault_count < MAX_PRINTS)
            $display("%0t ERROR: %s", $realtime, msg);
        fault_count++;
    endtask

    // Offer one request, wait for its transfer, record what should come back
    task automatic offer_item(input siq_req_t item, input bit typed,
                              input siq_rsp_t want);
        siq_rsp_t predicted;
        req_valid <= 1'b1;
        req       <= item;
        do @(posedge clk); while (req_stall);
        predicted = apply_to_store(item);
        if (predicted.status == ST_FULL)
            full_refusals++;
        if (predicted.status == ST_EMPTY)
            empty_pops++;
        awaited_results.push_back(typed ? want : predicted);
        sent_count++;
        // occasional gap on the request side
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // Response side: check each transfer, stall in short random bursts
    initial
    begin : rsp_side
        int       burst;
        siq_rsp_t wanted;
        burst     = 0;
        rsp_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid === 1'b1 && !rsp_stall)
            begin
                checked_count++;
                if (awaited_results.size() == 0)
                begin
                    report_fault("result transfer with nothing outstanding");
                end
                else
                begin
                    wanted = awaited_results.pop_front();
                    if (rsp.popped_value !== wanted.popped_value)
                        report_fault($sformatf("popped_value got %0d want %0d",
                                     rsp.popped_value, wanted.popped_value));
                    if (rsp.status !== wanted.status)
                        report_fault($sformatf("status got %0d want %0d",
                                     rsp.status, wanted.status));
                    if (rsp.count !== wanted.count)
                        report_fault($sformatf("count got %0d want %0d",
                                     rsp.count, wanted.count));
                end
            end
            if (burst > 0)
                burst--;
            else if (!calm && $urandom_range(0, 4) == 0)
                burst = $urandom_range(1, 4);
            rsp_stall <= long_hold || (burst > 0);
        end
    end

    // Long receiver hold-off so the block backs up and stalls its input
    initial
    begin : hold_off
        long_hold = 1'b0;
        wait (sent_count >= HOLD_AT);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold <= 1'b0;
    end

    // Watchdog
    initial
    begin : watchdog
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= LIMIT_CYCLES)
            begin
                $display("Timed out after %0d cycles", cycle_count);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Main sequence
    initial
    begin : request_side
        siq_req_t    item;
        siq_rsp_t    want;
        phase_mode_t mode;
        int          phase_left;
        int          push_pct;
        int          n;
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req           = '0;
        calm          = 1'b0;
        sent_count    = 0;
        full_refusals = 0;
        empty_pops    = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int r = 0; r < N_ROWS; r++)
        begin
            item.cmd          = stim_rows[r].cmd;
            item.value        = stim_rows[r].value;
            want.popped_value = stim_rows[r].want_value;
            want.status       = stim_rows[r].want_status;
            want.count        = stim_rows[r].want_count;
            offer_item(item, stim_rows[r].typed, want);
        end

        // random phases: fill to full, drain to empty, then mixed, repeating
        mode       = MODE_FILL;
        phase_left = $urandom_range(24, 48);
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS - CALM_TAIL)
                calm <= 1'b1;
            if (phase_left == 0)
            begin
                case (mode)
                    MODE_FILL:  mode = MODE_DRAIN;
                    MODE_DRAIN: mode = MODE_MIX;
                    default:    mode = MODE_FILL;
                endcase
                phase_left = $urandom_range(24, 48);
            end
            phase_left--;
            case (mode)
                MODE_FILL:  push_pct = 92;
                MODE_DRAIN: push_pct = 8;
                default:    push_pct = 50;
            endcase
            item.cmd = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
            // small range gives plenty of equal values; extremes now and then
            case ($urandom_range(0, 7))
                0, 1:    item.value = int'($urandom_range(0, 6)) - 3;
                2:       item.value = $urandom_range(0, 1) ? 32'sh7FFF_FFFF
                                                           : 32'sh8000_0000;
                default: item.value = $urandom;
            endcase
            offer_item(item, 1'b0, '0);
        end
        req_valid <= 1'b0;

        // drain outstanding results, then a few spare cycles
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d requests, checked %0d results in %0d cycles",
                 sent_count, checked_count, cycle_count);
        $display("Pushes refused on full store: %0d, pops on empty store: %0d",
                 full_refusals, empty_pops);
        if (fault_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/siq_pkg.sv
hw/rtl/siq_datapath.sv
hw/rtl/siq_controller.sv
hw/rtl/sorted_insert_priority_queue_unit.sv
dv/tb_sorted_insert_priority_queue_unit.sv
